[sv/pdim_pkg.sv]
// ----------------------------------------------------------------------------
// pdim_pkg
// Shared types and constants for the eight-channel phase-cut dimmer.
// ----------------------------------------------------------------------------
package pdim_pkg;

  // Field widths
  localparam int LVL_W     = 14;
  localparam int CMD_W     = 3;
  localparam int CH_W      = 4;
  localparam int VAL_W     = 16;
  localparam int GATE_W    = 8;
  localparam int SYNC_W    = 8;
  localparam int CFG_IDX_W = 2;

  // Defaults and limits
  localparam int CHANNELS_DEF = 8;
  localparam logic [LVL_W-1:0]  MIN_LEVEL_RST = LVL_W'(185);
  localparam logic [LVL_W-1:0]  PERIOD_RST    = LVL_W'(9900);
  localparam logic [SYNC_W-1:0] SYNC_MAX      = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = CFG_IDX_W'(1);

  // Command codes (6 and 7 are no-ops)
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_SYNC    = 3'd1,
    CMD_ALIVE   = 3'd2,
    CMD_SET     = 3'd3,
    CMD_SET_ALL = 3'd4,
    CMD_READ    = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CH_W-1:0]  channel;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [GATE_W-1:0] gate_bits;
    logic              alive_flag;
    logic [LVL_W-1:0]  level_read;
  } out_item_t;

endpackage

[sv/pdim_core.sv]
// ----------------------------------------------------------------------------
// pdim_core
// Dimmer state: levels, compares, down counter, sync watchdog and the
// configuration registers. Applies one accepted item per cycle and forms
// the result from the updated state.
// ----------------------------------------------------------------------------
module pdim_core #(
  parameter int CHANNELS = pdim_pkg::CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  pdim_pkg::in_item_t                   item,
  input  logic                                 cfg_we,
  input  logic [pdim_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pdim_pkg::LVL_W-1:0]           cfg_data,
  output pdim_pkg::out_item_t                  result
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = pdim_pkg::CH_W + 1;
  localparam logic [CNT_W-1:0] NUM_CH = CNT_W'(CHANNELS);

  logic [pdim_pkg::LVL_W-1:0]  min_level_r, period_r;
  logic [pdim_pkg::LVL_W-1:0]  levels_r   [CHANNELS];
  logic [pdim_pkg::LVL_W-1:0]  levels_nxt [CHANNELS];
  logic [pdim_pkg::LVL_W-1:0]  cmp_r      [CHANNELS];
  logic [pdim_pkg::LVL_W-1:0]  cmp_nxt    [CHANNELS];
  logic [pdim_pkg::LVL_W-1:0]  down_r, down_nxt;
  logic                        running_r, running_nxt;
  logic [pdim_pkg::SYNC_W-1:0] sync_r, sync_nxt;
  logic                        alive_r, alive_nxt;
  logic [pdim_pkg::LVL_W-1:0]  rd_level;
  logic [pdim_pkg::LVL_W-1:0]  dec_count;
  logic [pdim_pkg::LVL_W-1:0]  clamp_val, clamp_zero;
  logic                        ch_ok;
  logic [IDX_W-1:0]            ch_idx;
  logic [pdim_pkg::GATE_W-1:0] gates;

  // Clamp: raise to min_level, then cap at period
  function automatic logic [pdim_pkg::LVL_W-1:0] clamp_level(
    input logic [pdim_pkg::VAL_W-1:0] v,
    input logic [pdim_pkg::LVL_W-1:0] lo,
    input logic [pdim_pkg::LVL_W-1:0] hi
  );
    logic [pdim_pkg::VAL_W-1:0] t;
    t = v;
    if (t < pdim_pkg::VAL_W'(lo)) t = pdim_pkg::VAL_W'(lo);
    if (t > pdim_pkg::VAL_W'(hi)) t = pdim_pkg::VAL_W'(hi);
    return t[pdim_pkg::LVL_W-1:0];
  endfunction

  assign ch_ok      = {1'b0, item.channel} < NUM_CH;
  assign ch_idx     = item.channel[IDX_W-1:0];
  assign clamp_val  = clamp_level(item.value, min_level_r, period_r);
  assign clamp_zero = clamp_level('0, min_level_r, period_r);
  assign dec_count  = (down_r != '0) ? down_r - 1'b1 : down_r;

  // Next-state for the accepted command
  always_comb begin
    levels_nxt  = levels_r;
    cmp_nxt     = cmp_r;
    down_nxt    = down_r;
    running_nxt = running_r;
    sync_nxt    = sync_r;
    alive_nxt   = alive_r;
    rd_level    = '0;
    case (item.cmd)
      pdim_pkg::CMD_TICK: begin
        if (running_r) begin
          down_nxt = dec_count;
          if (dec_count == '0) running_nxt = 1'b0;
        end
      end
      pdim_pkg::CMD_SYNC: begin
        cmp_nxt = levels_r;
        if (!running_r && period_r != '0) begin
          down_nxt    = period_r;
          running_nxt = 1'b1;
        end
        if (sync_r != pdim_pkg::SYNC_MAX) sync_nxt = sync_r + 1'b1;
      end
      pdim_pkg::CMD_ALIVE: begin
        if (sync_r != '0) begin
          alive_nxt = 1'b1;
        end else begin
          if (!alive_r) begin
            for (int i = 0; i < CHANNELS; i++) levels_nxt[i] = clamp_zero;
          end
          alive_nxt = 1'b0;
        end
        sync_nxt = '0;
      end
      pdim_pkg::CMD_SET: begin
        if (ch_ok) levels_nxt[ch_idx] = clamp_val;
      end
      pdim_pkg::CMD_SET_ALL: begin
        for (int i = 0; i < CHANNELS; i++) levels_nxt[i] = clamp_val;
      end
      pdim_pkg::CMD_READ: begin
        if (ch_ok) rd_level = levels_r[ch_idx];
      end
      default: begin
      end
    endcase
  end

  // Gate compares on the updated state; channels beyond the count read low
  for (genvar gi = 0; gi < pdim_pkg::GATE_W; gi++) begin : g_gate
    if (gi < CHANNELS) begin : g_on
      assign gates[gi] = running_nxt && (down_nxt <= cmp_nxt[gi]);
    end else begin : g_off
      assign gates[gi] = 1'b0;
    end
  end

  assign result.gate_bits  = gates;
  assign result.alive_flag = alive_nxt;
  assign result.level_read = rd_level;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_level_r <= pdim_pkg::MIN_LEVEL_RST;
      period_r    <= pdim_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      if (cfg_index == pdim_pkg::REG_MIN_LEVEL) min_level_r <= cfg_data;
      if (cfg_index == pdim_pkg::REG_PERIOD)    period_r    <= cfg_data;
    end
  end

  // Dimmer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        levels_r[i] <= '0;
        cmp_r[i]    <= '0;
      end
      down_r    <= '0;
      running_r <= 1'b0;
      sync_r    <= '0;
      alive_r   <= 1'b0;
    end else if (accept) begin
      levels_r  <= levels_nxt;
      cmp_r     <= cmp_nxt;
      down_r    <= down_nxt;
      running_r <= running_nxt;
      sync_r    <= sync_nxt;
      alive_r   <= alive_nxt;
    end
  end

endmodule

[sv/pdim_out_buf.sv]
// ----------------------------------------------------------------------------
// pdim_out_buf
// Result register with a skid entry. Takes a new item while the head
// item waits; stalls upstream only when both entries hold.
// ----------------------------------------------------------------------------
module pdim_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pdim_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output pdim_pkg::out_item_t out_item
);

  logic                head_vld_r, head_vld_nxt;
  logic                skid_vld_r, skid_vld_nxt;
  pdim_pkg::out_item_t head_r, head_nxt;
  pdim_pkg::out_item_t skid_r, skid_nxt;
  logic                take;

  assign take = head_vld_r && !out_stall;

  // Head refills from skid first, then from the new item
  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (!head_vld_r || take) begin
      if (skid_vld_r) begin
        head_nxt     = skid_r;
        head_vld_nxt = 1'b1;
        skid_vld_nxt = 1'b0;
      end else if (push) begin
        head_nxt     = push_item;
        head_vld_nxt = 1'b1;
      end else begin
        head_vld_nxt = 1'b0;
      end
    end else if (push) begin
      skid_nxt     = push_item;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_item  = head_r;

endmodule

[sv/phase_cut_dimmer_8ch.sv]
// ----------------------------------------------------------------------------
// phase_cut_dimmer_8ch
// Eight-channel mains phase-cut dimmer with level clamp and sync watchdog.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low (tick, sync edge, alive check,
// set level, set all, read level) and returns exactly one registered result per
// item. The whole update is a single compare/decrement pass over the state
// registers, so the sustained rate is one item per cycle unless the output
// stalls. A two-entry result buffer lets the block keep accepting while one
// result is held by a stall; in_stall rises only when both entries are full.
// Configuration writes (index 0 min_level, 1 period) should come while idle.
module phase_cut_dimmer_8ch #(
  parameter int CHANNELS = pdim_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pdim_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pdim_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [pdim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdim_pkg::LVL_W-1:0]     cfg_data
);

  logic                accept;
  logic                buf_full;
  pdim_pkg::out_item_t result;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  // State update
  pdim_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  // Result register and skid
  pdim_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
